// ----- hdl/mcet_pkg.sv -----
package mcet_pkg;

   localparam int CHANNELS = 8;
   localparam int MAX_RES  = 16;
   // Index width: at least the 3 bits of the channel field
   localparam int IDX_W    = (CHANNELS > 8) ? $clog2(CHANNELS) : 3;
   localparam int CNT_W    = $clog2(MAX_RES + 1);

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_REG   = 2'd1;
   localparam logic [1:0] OP_UNREG = 2'd2;

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_FIRE   = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [2:0]  channel;
      logic [31:0] period;
      logic        reload_mode;
      logic [15:0] repeats;
      logic        fire_enable;
      logic        finish_enable;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] event_channel;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic wr;
      logic clr;
   } cell_cmd_type;

   typedef struct packed {
      logic fire;
      logic finish;
   } cell_ev_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WALK  = 3'b010,
      ST_FINAL = 3'b100
   } state_type;

endpackage

// ----- hdl/mcet_cell.sv -----
module mcet_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  mcet_pkg::cell_cmd_type cmd,
   input  mcet_pkg::req_type     req,
   input  logic                  shift,
   input  logic                  step,
   input  logic                  token_in,
   output logic                  token_out,
   output mcet_pkg::cell_ev_type ev
);
   import mcet_pkg::*;

   logic [31:0] remaining_ff, remaining_in;
   logic [31:0] period_ff, period_in;
   logic        reload_ff, reload_in;
   logic [15:0] repeat_ff, repeat_in;
   logic        active_ff, active_in;
   logic        finflag_ff, finflag_in;
   logic        token_ff, token_in_nxt;

   logic [31:0] rem_dec;
   logic        upd;
   logic        fire;

   assign upd     = token_ff && step && active_ff;
   assign rem_dec = (remaining_ff != 32'd0) ? remaining_ff - 32'd1 : remaining_ff;
   assign fire    = upd && (rem_dec == 32'd0);

   assign ev.fire   = fire;
   assign ev.finish = fire && !reload_ff && (repeat_ff == 16'd1) && finflag_ff;
   assign token_out = token_ff;

   always_comb begin
      remaining_in = remaining_ff;
      period_in    = period_ff;
      reload_in    = reload_ff;
      repeat_in    = repeat_ff;
      active_in    = active_ff;
      finflag_in   = finflag_ff;
      token_in_nxt = shift ? token_in : token_ff;

      if (cmd.wr) begin
         remaining_in = req.period;
         period_in    = req.period;
         reload_in    = (req.repeats != 16'd0) ? 1'b0 : req.reload_mode;
         repeat_in    = req.repeats;
         active_in    = req.fire_enable;
         finflag_in   = req.finish_enable;
      end else if (cmd.clr) begin
         active_in = 1'b0;
      end else if (upd) begin
         remaining_in = rem_dec;
         if (fire) begin
            if (reload_ff) begin
               remaining_in = period_ff;
            end else if (repeat_ff != 16'd0) begin
               repeat_in    = repeat_ff - 16'd1;
               remaining_in = period_ff;
               if (repeat_ff == 16'd1) begin
                  active_in = 1'b0;
               end
            end else begin
               active_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         period_ff    <= '0;
         reload_ff    <= 1'b0;
         repeat_ff    <= '0;
         active_ff    <= 1'b0;
         finflag_ff   <= 1'b0;
         token_ff     <= 1'b0;
      end else begin
         remaining_ff <= remaining_in;
         period_ff    <= period_in;
         reload_ff    <= reload_in;
         repeat_ff    <= repeat_in;
         active_ff    <= active_in;
         finflag_ff   <= finflag_in;
         token_ff     <= token_in_nxt;
      end
   end

endmodule

// ----- hdl/multi_channel_event_timer.sv -----
// Channel   | Ports                       | Handshake
// ----------+-----------------------------+-----------------------------------------
// request   | start, busy, req_data       | transfer when start high and busy low
// result    | rsp_strobe, rsp_data        | one cycle per result, no back pressure
//
// Register and unregister items are acknowledged on the cycle after the transfer.
// A tick walks a token down the row of channel cells, one cell per cycle, pausing
// while each finish event goes out, and ends in a closing state that issues the
// last result.
// Synchronous reset clears all channel state, the walk and the result strobe.
// Results can not be stalled; busy stays high until the last one is issued.
module multi_channel_event_timer (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mcet_pkg::req_type req_data,
   output logic              rsp_strobe,
   output mcet_pkg::rsp_type rsp_data
);
   import mcet_pkg::*;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  walk_idx_ff, walk_idx_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic              hold_v_ff, hold_v_in;
   rsp_type           hold_ff, hold_in;
   logic              fin_pend_ff, fin_pend_in;
   logic [2:0]        fin_ch_ff, fin_ch_in;
   logic              end_ff, end_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_ff, rsp_in;

   logic              item_go;
   logic              tick_go;
   logic              step;
   logic              shift;
   logic [CHANNELS:0] tok;
   cell_ev_type       cell_ev [CHANNELS];
   cell_ev_type       ev;
   logic              push_v;
   logic [1:0]        push_kind;
   logic [2:0]        push_ch;

   assign busy    = (state_ff != ST_IDLE);
   assign item_go = start && !busy;
   assign tick_go = item_go && (req_data.op == OP_TICK);
   // Hold the token while a finish event goes out
   assign step    = (state_ff == ST_WALK) && !fin_pend_ff;
   assign shift   = tick_go || step;
   assign tok[0]  = tick_go;

   // Row of channel cells; the walk token hops one cell per step
   for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
      cell_cmd_type cmd;
      assign cmd.wr  = item_go && (req_data.op == OP_REG) &&
                       (IDX_W'(req_data.channel) == IDX_W'(i));
      assign cmd.clr = item_go && (req_data.op == OP_UNREG) &&
                       (IDX_W'(req_data.channel) == IDX_W'(i));
      mcet_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .req       (req_data),
         .shift     (shift),
         .step      (step),
         .token_in  (tok[i]),
         .token_out (tok[i+1]),
         .ev        (cell_ev[i])
      );
   end

   // Only the cell holding the token reports, so an OR gathers its event
   always_comb begin
      ev = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         ev = ev | cell_ev[i];
      end
   end

   always_comb begin
      push_v    = 1'b0;
      push_kind = KIND_NONE;
      push_ch   = 3'd0;
      if (state_ff == ST_WALK) begin
         if (fin_pend_ff) begin
            push_v    = 1'b1;
            push_kind = KIND_FINISH;
            push_ch   = fin_ch_ff;
         end else if (ev.fire) begin
            push_v    = 1'b1;
            push_kind = KIND_FIRE;
            push_ch   = walk_idx_ff[2:0];
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      walk_idx_in   = walk_idx_ff;
      n_in          = n_ff;
      hold_v_in     = hold_v_ff;
      hold_in       = hold_ff;
      fin_pend_in   = fin_pend_ff;
      fin_ch_in     = fin_ch_ff;
      end_in        = end_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      // Keep one event back so the final one can carry last; drop past the cap
      if (push_v && (n_ff < CNT_W'(MAX_RES))) begin
         if (hold_v_ff) begin
            rsp_strobe_in = 1'b1;
            rsp_in        = hold_ff;
            rsp_in.last   = 1'b0;
         end
         hold_in.kind          = push_kind;
         hold_in.event_channel = push_ch;
         hold_in.last          = 1'b0;
         hold_v_in             = 1'b1;
         n_in                  = n_ff + 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (tick_go) begin
               walk_idx_in = '0;
               n_in        = '0;
               hold_v_in   = 1'b0;
               fin_pend_in = 1'b0;
               end_in      = 1'b0;
               state_in    = ST_WALK;
            end else if (item_go) begin
               // Register, unregister and unknown ops: acknowledge only
               rsp_strobe_in        = 1'b1;
               rsp_in.kind          = KIND_NONE;
               rsp_in.event_channel = 3'd0;
               rsp_in.last          = 1'b1;
            end
         end
         ST_WALK: begin
            if (fin_pend_ff) begin
               fin_pend_in = 1'b0;
               if (end_ff) begin
                  state_in = ST_FINAL;
               end
            end else begin
               if (ev.finish) begin
                  fin_pend_in = 1'b1;
                  fin_ch_in   = walk_idx_ff[2:0];
               end
               if (walk_idx_ff == IDX_W'(CHANNELS - 1)) begin
                  end_in = 1'b1;
                  if (!ev.finish) begin
                     state_in = ST_FINAL;
                  end
               end else begin
                  walk_idx_in = walk_idx_ff + 1'b1;
               end
            end
         end
         ST_FINAL: begin
            // Flush the held event with last, or report a quiet tick
            rsp_strobe_in = 1'b1;
            if (hold_v_ff) begin
               rsp_in = hold_ff;
            end else begin
               rsp_in.kind          = KIND_NONE;
               rsp_in.event_channel = 3'd0;
            end
            rsp_in.last = 1'b1;
            hold_v_in   = 1'b0;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         walk_idx_ff   <= '0;
         n_ff          <= '0;
         hold_v_ff     <= 1'b0;
         fin_pend_ff   <= 1'b0;
         end_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         walk_idx_ff   <= walk_idx_in;
         n_ff          <= n_in;
         hold_v_ff     <= hold_v_in;
         fin_pend_ff   <= fin_pend_in;
         end_ff        <= end_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff   <= hold_in;
      fin_ch_ff <= fin_ch_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- tb/multi_channel_event_timer_tb.sv -----
module multi_channel_event_timer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mcet_pkg::*;

   // Op code the block does not define; it must still be acknowledged
   localparam logic [1:0] OP_SPARE = 2'd3;

   // One row of the directed table: the request, plus a hand-written
   // expectation for rows whose single result is obvious.
   typedef struct {
      req_type req;
      bit      known;
      rsp_type rsp;
   } stim_row_type;

   // Travels with each request from the driver to the scoreboard.
   typedef struct {
      bit      known;
      rsp_type rsp;
   } item_note_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // Shadow copy of the timer bank
   logic [31:0] count_left   [CHANNELS];
   logic [31:0] period_store [CHANNELS];
   logic        reload_on    [CHANNELS];
   logic [15:0] repeats_left [CHANNELS];
   logic        chan_active  [CHANNELS];
   logic        finish_on    [CHANNELS];

   rsp_type       step_events[$];    // events of the request just predicted
   rsp_type       pending_events[$]; // events still to come out of the block
   item_note_type item_notes[$];     // one per request driven, oldest first
   stim_row_type  directed_rows[$];
   int            error_count = 0;

   multi_channel_event_timer dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #5 clock = ~clock;

   // Drop events beyond the per-request limit, as the block does.
   function automatic void add_event(logic [1:0] kind, int ch);
      if (step_events.size() < MAX_RES) begin
         step_events.push_back(rsp_type'{kind, 3'(ch), 1'b0});
      end
   endfunction

   // Apply one request to the shadow bank and collect the events it causes.
   function automatic void advance_timers(req_type r);
      int i;
      step_events.delete();
      case (r.op)
         OP_TICK: begin
            // Walk channels in index order; only active ones count.
            for (i = 0; i < CHANNELS; i++) begin
               if (!chan_active[i]) continue;
               if (count_left[i] != 0) count_left[i] = count_left[i] - 32'd1;
               if (count_left[i] != 0) continue;
               add_event(KIND_FIRE, i);
               if (reload_on[i]) begin
                  count_left[i] = period_store[i];
               end else if (repeats_left[i] != 0) begin
                  repeats_left[i] = repeats_left[i] - 16'd1;
                  count_left[i]   = period_store[i];
                  if (repeats_left[i] == 0) begin
                     if (finish_on[i]) add_event(KIND_FINISH, i);
                     chan_active[i] = 1'b0;
                  end
               end else begin
                  chan_active[i] = 1'b0;
               end
            end
         end
         OP_REG: begin
            if (int'(r.channel) < CHANNELS) begin
               count_left[r.channel]   = r.period;
               period_store[r.channel] = r.period;
               // A nonzero repeat count overrides reload mode
               reload_on[r.channel]    = (r.repeats != 0) ? 1'b0 : r.reload_mode;
               repeats_left[r.channel] = r.repeats;
               chan_active[r.channel]  = r.fire_enable;
               finish_on[r.channel]    = r.finish_enable;
            end
         end
         OP_UNREG: begin
            // Only the active flag goes; the rest of the channel is kept
            if (int'(r.channel) < CHANNELS) chan_active[r.channel] = 1'b0;
         end
         default: ;
      endcase
      // Quiet tick, acknowledge or unknown op: one empty result
      if (step_events.size() == 0) add_event(KIND_NONE, 0);
      step_events[step_events.size() - 1].last = 1'b1;
   endfunction

   function automatic req_type make_req(logic [1:0] op, int ch, logic [31:0] per,
                                        bit rmode, logic [15:0] reps, bit fen,
                                        bit finen);
      req_type r;
      r.op            = op;
      r.channel       = 3'(ch);
      r.period        = per;
      r.reload_mode   = rmode;
      r.repeats       = reps;
      r.fire_enable   = fen;
      r.finish_enable = finen;
      return r;
   endfunction

   function automatic stim_row_type stim_row(req_type r, bit known,
                                             logic [1:0] kind, int ech);
      stim_row_type s;
      s.req   = r;
      s.known = known;
      s.rsp   = rsp_type'{kind, 3'(ech), 1'b1};
      return s;
   endfunction

   // Random request: mostly short periods so channels fire often, with the
   // odd full-width value to cover every bit.
   function automatic req_type random_item();
      req_type     r;
      int          pick;
      logic [31:0] per;
      logic [15:0] reps;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: per = $urandom_range(0, 4);
         6:                per = '0;
         7:                per = $urandom;
         8:                per = '1;
         default:          per = $urandom_range(5, 20);
      endcase
      case ($urandom_range(0, 7))
         0, 1, 2, 3: reps = '0;
         4, 5:       reps = 16'($urandom_range(1, 3));
         6:          reps = 16'($urandom);
         default:    reps = '1;
      endcase
      r = make_req(OP_REG, $urandom_range(0, 7), per, 1'($urandom_range(0, 1)), reps,
                   $urandom_range(0, 5) != 0, 1'($urandom_range(0, 1)));
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         r.op = OP_TICK;
      end else if (pick < 82) begin
         r.op = OP_REG;
      end else if (pick < 97) begin
         r.op = OP_UNREG;
      end else begin
         r.op = OP_SPARE;
      end
      return r;
   endfunction

   // Scoreboard: check results first, then predict any transfer at this edge.
   // Everything here sees pre-edge values, so the order against the driver
   // inside a time step does not matter.
   always @(posedge clock) begin : scoreboard
      rsp_type       want;
      item_note_type note;
      if (!reset && rsp_strobe) begin
         if (pending_events.size() == 0) begin
            $error("unexpected result: kind %0d event_channel %0d last %0d",
                   rsp_data.kind, rsp_data.event_channel, rsp_data.last);
            error_count++;
         end else begin
            want = pending_events.pop_front();
            if (rsp_data.kind !== want.kind) begin
               $error("kind: expected %0d, actual %0d", want.kind, rsp_data.kind);
               error_count++;
            end
            if (rsp_data.event_channel !== want.event_channel) begin
               $error("event_channel: expected %0d, actual %0d",
                      want.event_channel, rsp_data.event_channel);
               error_count++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_data.last);
               error_count++;
            end
         end
      end
      if (!reset && start && !busy) begin
         note = item_notes.pop_front();
         // Always run the shadow bank so its state stays in step
         advance_timers(req_data);
         if (note.known) begin
            pending_events.push_back(note.rsp);
         end else begin
            foreach (step_events[k]) pending_events.push_back(step_events[k]);
         end
      end
   end

   // Present one request and hold it until the transfer edge.
   task automatic send_item(req_type item, bit known, rsp_type typed);
      item_notes.push_back(item_note_type'{known, typed});
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Lower start for a few cycles, optionally until every event is out.
   task automatic idle_sender(int cycles, bit drain);
      start <= 1'b0;
      @(posedge clock);
      repeat ((cycles > 0) ? cycles - 1 : 0) @(posedge clock);
      if (drain) begin
         while (pending_events.size() != 0) @(posedge clock);
      end
   endtask

   task automatic send_with_gap(req_type item, bit known, rsp_type typed, bit calm);
      int gap;
      send_item(item, known, typed);
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) idle_sender(gap, 1'b0);
   endtask

   initial begin : stimulus
      int      sent;
      bit      calm;
      rsp_type none_rsp;
      none_rsp = '0;

      // Clear the shadow bank, as reset clears the block
      for (int i = 0; i < CHANNELS; i++) begin
         count_left[i]   = '0;
         period_store[i] = '0;
         reload_on[i]    = 1'b0;
         repeats_left[i] = '0;
         chan_active[i]  = 1'b0;
         finish_on[i]    = 1'b0;
      end

      // Directed table: idle tick, one-shot zero period, reload, repeats,
      // extreme period and repeats, inactive register, unregister, unknown op
      directed_rows.push_back(stim_row(make_req(OP_TICK, 0, 0, 0, 0, 0, 0),
                                       1, KIND_NONE, 0));
      directed_rows.push_back(stim_row(make_req(OP_REG, 0, 0, 0, 0, 1, 1),
                                       1, KIND_NONE, 0));
      directed_rows.push_back(stim_row(make_req(OP_TICK, 0, 0, 0, 0, 0, 0),
                                       1, KIND_FIRE, 0));
      directed_rows.push_back(stim_row(make_req(OP_TICK, 0, 0, 0, 0, 0, 0),
                                       1, KIND_NONE, 0));
      directed_rows.push_back(stim_row(make_req(OP_REG, 7, 1, 1, 0, 1, 0),
                                       1, KIND_NONE, 0));
      directed_rows.push_back(stim_row(make_req(OP_REG, 3, 2, 1, 2, 1, 1),
                                       1, KIND_NONE, 0));
      directed_rows.push_back(stim_row(make_req(OP_REG, 5, '1, 1, '1, 1, 1),
                                       1, KIND_NONE, 0));
      directed_rows.push_back(stim_row(make_req(OP_REG, 1, 3, 0, 0, 0, 1),
                                       1, KIND_NONE, 0));
      repeat (6) begin
         directed_rows.push_back(stim_row(make_req(OP_TICK, 0, 0, 0, 0, 0, 0),
                                          0, KIND_NONE, 0));
      end
      directed_rows.push_back(stim_row(make_req(OP_UNREG, 7, 0, 0, 0, 0, 0),
                                       1, KIND_NONE, 0));
      directed_rows.push_back(stim_row(make_req(OP_TICK, 0, 0, 0, 0, 0, 0),
                                       0, KIND_NONE, 0));
      directed_rows.push_back(stim_row(make_req(OP_SPARE, 7, '1, 1, '1, 1, 1),
                                       1, KIND_NONE, 0));
      directed_rows.push_back(stim_row(make_req(OP_REG, 2, 0, 1, 0, 1, 0),
                                       1, KIND_NONE, 0));
      directed_rows.push_back(stim_row(make_req(OP_REG, 4, 0, 0, 1, 1, 1),
                                       1, KIND_NONE, 0));
      repeat (2) begin
         directed_rows.push_back(stim_row(make_req(OP_TICK, 0, 0, 0, 0, 0, 0),
                                          0, KIND_NONE, 0));
      end
      directed_rows.push_back(stim_row(make_req(OP_UNREG, 2, 0, 0, 0, 0, 0),
                                       1, KIND_NONE, 0));
      directed_rows.push_back(stim_row(make_req(OP_UNREG, 5, 0, 0, 0, 0, 0),
                                       1, KIND_NONE, 0));
      directed_rows.push_back(stim_row(make_req(OP_TICK, 0, 0, 0, 0, 0, 0),
                                       0, KIND_NONE, 0));

      // Hold reset at the start, then leave it low for good
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      foreach (directed_rows[n]) begin
         send_with_gap(directed_rows[n].req, directed_rows[n].known,
                       directed_rows[n].rsp, 1'b0);
      end

      // Let the bank drain before the random part
      idle_sender(0, 1'b1);

      sent = 0;
      while (sent < 400) begin
         // Alternate stretches with random gaps and back-to-back transfers
         calm = ((sent / 40) % 3) == 2;
         if ($urandom_range(0, 39) == 0) begin
            // Arm every channel to fire and finish on the same tick: the
            // fullest result burst the block can produce
            for (int c = 0; c < CHANNELS; c++) begin
               send_with_gap(make_req(OP_REG, c, 0, 1'($urandom_range(0, 1)), 1, 1, 1),
                             1'b0, none_rsp, calm);
            end
            send_with_gap(make_req(OP_TICK, 0, 0, 0, 0, 0, 0), 1'b0, none_rsp, calm);
            sent += CHANNELS + 1;
         end else begin
            send_with_gap(random_item(), 1'b0, none_rsp, calm);
            sent++;
         end
         // Now and then hold the sender until the block has caught up
         if ($urandom_range(0, 99) == 0) idle_sender(0, 1'b1);
      end

      // Drain, then give the block a full walk's worth of extra cycles
      idle_sender(0, 1'b1);
      repeat (20) @(posedge clock);
      if (pending_events.size() != 0) begin
         $error("%0d expected results never arrived", pending_events.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin : watchdog
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
